// ===== rtl/core/ptbe_pkg.sv =====
package ptbe_pkg;

  // fixed point format
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned COORD_W   = 17;
  localparam int unsigned NODE_W    = 4;
  localparam int unsigned AXIS_W    = 2;
  localparam int unsigned OUT_W     = 19;

  // width of x+y+z and of the signed working word
  localparam int unsigned SUM_W = COORD_W + 2;
  localparam int unsigned EXT_W = SUM_W + 4;

  // item kinds
  localparam logic KIND_VALUE = 1'b0;
  localparam logic KIND_DERIV = 1'b1;

  // derivative directions
  localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
  localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
  localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

  // nodes: codes 0..3 are the vertices, codes 4..9 the edge midpoints
  localparam logic [NODE_W-1:0] NODE_V0  = 4'd0;
  localparam logic [NODE_W-1:0] NODE_V1  = 4'd1;
  localparam logic [NODE_W-1:0] NODE_V2  = 4'd2;
  localparam logic [NODE_W-1:0] NODE_V3  = 4'd3;
  localparam logic [NODE_W-1:0] NODE_M01 = 4'd4;
  localparam logic [NODE_W-1:0] NODE_M12 = 4'd5;
  localparam logic [NODE_W-1:0] NODE_M02 = 4'd6;
  localparam logic [NODE_W-1:0] NODE_M03 = 4'd7;
  localparam logic [NODE_W-1:0] NODE_M13 = 4'd8;
  localparam logic [NODE_W-1:0] NODE_M23 = 4'd9;

  // constants in coordinate and working formats
  localparam logic [SUM_W-1:0]        HALF      = SUM_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [EXT_W-1:0] ONE_E     = EXT_W'(1) << FRAC_BITS;
  localparam logic signed [EXT_W-1:0] TWO_E     = EXT_W'(1) << (FRAC_BITS + 1);
  localparam logic signed [EXT_W-1:0] OUT_MAX_E = EXT_W'((1 << (OUT_W - 1)) - 1);
  localparam logic signed [EXT_W-1:0] OUT_MIN_E = -OUT_MAX_E - EXT_W'(1);

  // derivative results in output format
  localparam logic signed [OUT_W-1:0] TWO_O     = OUT_W'(1) << (FRAC_BITS + 1);
  localparam logic signed [OUT_W-1:0] NEG_TWO_O = -TWO_O;

  // sub-tetrahedron tests for one point
  typedef struct packed {
    logic c0;
    logic c1;
    logic c2;
    logic c3;
    logic ra;
    logic rb;
    logic rd;
    logic re;
  } region_t;

endpackage

// ===== rtl/core/p1isop2_tet_basis_eval_top.sv =====
// P1-iso-P2 tetrahedron basis evaluator. Each item gives one point (x, y, z
// unsigned, FRAC_BITS fraction bits), a node 0..9, and either a basis value
// or a first partial derivative along one axis; one signed result item comes
// back per input item. The point is sorted into the eight half-size
// sub-tetrahedra by compares of x, y, z, x+y, x+z and x+y+z against one half,
// and the first matching branch for the node picks a linear formula or a
// constant; nothing matching gives 0, and results saturate to 19 bits. One
// item is accepted every cycle while the output side does not stall; an item
// passes through the input register, then the result register, and is held
// back only while the output side stalls.
module p1isop2_tet_basis_eval_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 kind_i,
  input  logic [ptbe_pkg::NODE_W-1:0]          node_i,
  input  logic [ptbe_pkg::AXIS_W-1:0]          axis_i,
  input  logic [ptbe_pkg::COORD_W-1:0]         coord_x_i,
  input  logic [ptbe_pkg::COORD_W-1:0]         coord_y_i,
  input  logic [ptbe_pkg::COORD_W-1:0]         coord_z_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [ptbe_pkg::OUT_W-1:0]    value_o
);

  localparam int unsigned SW = ptbe_pkg::SUM_W;
  localparam int unsigned EW = ptbe_pkg::EXT_W;
  localparam int unsigned CW = ptbe_pkg::COORD_W;

  // input register
  logic                           s1_vld_q, s1_vld_d;
  logic                           s1_kind_q;
  logic [ptbe_pkg::NODE_W-1:0]    s1_node_q;
  logic [ptbe_pkg::AXIS_W-1:0]    s1_axis_q;
  logic [CW-1:0]                  s1_x_q, s1_y_q, s1_z_q;

  // result register
  logic                           out_vld_q, out_vld_d;
  logic signed [ptbe_pkg::OUT_W-1:0] value_q;

  logic in_acc;
  logic s1_adv;

  // handshake
  assign s1_adv     = s1_vld_q & (~out_vld_q | ~out_stall_i);
  assign in_stall_o = s1_vld_q & ~s1_adv;
  assign in_acc     = in_valid_i & ~in_stall_o;

  always_comb begin
    s1_vld_d = s1_vld_q;
    if (in_acc) begin
      s1_vld_d = 1'b1;
    end else if (s1_adv) begin
      s1_vld_d = 1'b0;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (s1_adv) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      s1_vld_q  <= s1_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // input payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_kind_q <= kind_i;
      s1_node_q <= node_i;
      s1_axis_q <= axis_i;
      s1_x_q    <= coord_x_i;
      s1_y_q    <= coord_y_i;
      s1_z_q    <= coord_z_i;
    end
  end

  // coordinate sums
  logic [SW-1:0] ux, uy, uz, sxy, sxz, sxyz;

  assign ux   = SW'(s1_x_q);
  assign uy   = SW'(s1_y_q);
  assign uz   = SW'(s1_z_q);
  assign sxy  = ux + uy;
  assign sxz  = ux + uz;
  assign sxyz = sxy + uz;

  // region tests, all inclusive
  ptbe_pkg::region_t rg;

  always_comb begin
    rg.c0 = sxyz <= ptbe_pkg::HALF;
    rg.c1 = ux >= ptbe_pkg::HALF;
    rg.c2 = uy >= ptbe_pkg::HALF;
    rg.c3 = uz >= ptbe_pkg::HALF;
    rg.ra = (uz <= ptbe_pkg::HALF) & (sxz >= ptbe_pkg::HALF) & (sxy <= ptbe_pkg::HALF);
    rg.rb = (ux <= ptbe_pkg::HALF) & (sxy >= ptbe_pkg::HALF) & (sxz >= ptbe_pkg::HALF);
    rg.rd = (uy <= ptbe_pkg::HALF) & (sxz <= ptbe_pkg::HALF) & (sxy >= ptbe_pkg::HALF);
    rg.re = (sxy <= ptbe_pkg::HALF) & (sxz <= ptbe_pkg::HALF) & (sxyz >= ptbe_pkg::HALF);
  end

  // linear pieces in the signed working format
  logic signed [EW-1:0] ex, ey, ez, exy, exz, exyz;
  logic signed [EW-1:0] f_x2, f_y2, f_z2;
  logic signed [EW-1:0] f_x2m1, f_y2m1, f_z2m1;
  logic signed [EW-1:0] f_1m2z, f_1m2y, f_1m2x;
  logic signed [EW-1:0] f_1m2xyz, f_2rest, f_xy2m1, f_xz2m1, f_xyz2m1;
  logic signed [EW-1:0] f_1m2xz, f_1m2xy;

  assign ex   = signed'(EW'(ux));
  assign ey   = signed'(EW'(uy));
  assign ez   = signed'(EW'(uz));
  assign exy  = signed'(EW'(sxy));
  assign exz  = signed'(EW'(sxz));
  assign exyz = signed'(EW'(sxyz));

  assign f_x2     = ex <<< 1;
  assign f_y2     = ey <<< 1;
  assign f_z2     = ez <<< 1;
  assign f_x2m1   = f_x2 - ptbe_pkg::ONE_E;
  assign f_y2m1   = f_y2 - ptbe_pkg::ONE_E;
  assign f_z2m1   = f_z2 - ptbe_pkg::ONE_E;
  assign f_1m2x   = ptbe_pkg::ONE_E - f_x2;
  assign f_1m2y   = ptbe_pkg::ONE_E - f_y2;
  assign f_1m2z   = ptbe_pkg::ONE_E - f_z2;
  assign f_1m2xyz = ptbe_pkg::ONE_E - (exyz <<< 1);
  assign f_2rest  = ptbe_pkg::TWO_E - (exyz <<< 1);
  assign f_xy2m1  = (exy <<< 1) - ptbe_pkg::ONE_E;
  assign f_xz2m1  = (exz <<< 1) - ptbe_pkg::ONE_E;
  assign f_xyz2m1 = (exyz <<< 1) - ptbe_pkg::ONE_E;
  assign f_1m2xz  = ptbe_pkg::ONE_E - (exz <<< 1);
  assign f_1m2xy  = ptbe_pkg::ONE_E - (exy <<< 1);

  // branch selection, first match wins
  logic a0, a1, a2;
  logic signed [EW-1:0] val_e, dv_e, res_e;
  logic signed [EW-1:0] p2, n2;

  assign a0 = s1_axis_q == ptbe_pkg::AXIS_X;
  assign a1 = s1_axis_q == ptbe_pkg::AXIS_Y;
  assign a2 = s1_axis_q == ptbe_pkg::AXIS_Z;
  assign p2 = ptbe_pkg::TWO_E;
  assign n2 = -ptbe_pkg::TWO_E;

  // basis value
  always_comb begin
    val_e = '0;
    unique case (s1_node_q)
      ptbe_pkg::NODE_V0: if (rg.c0) val_e = f_1m2xyz;
      ptbe_pkg::NODE_V1: if (rg.c1) val_e = f_x2m1;
      ptbe_pkg::NODE_V2: if (rg.c2) val_e = f_y2m1;
      ptbe_pkg::NODE_V3: if (rg.c3) val_e = f_z2m1;
      ptbe_pkg::NODE_M01: begin
        priority if (rg.c0 | rg.re) val_e = f_x2;
        else if (rg.c1 | rg.rb)     val_e = f_2rest;
        else if (rg.ra)             val_e = f_1m2z;
        else if (rg.rd)             val_e = f_1m2y;
        else                        val_e = '0;
      end
      ptbe_pkg::NODE_M12: begin
        priority if (rg.c1)     val_e = f_y2;
        else if (rg.c2)         val_e = f_x2;
        else if (rg.rb | rg.rd) val_e = f_xy2m1;
        else                    val_e = '0;
      end
      ptbe_pkg::NODE_M02: begin
        priority if (rg.c0)     val_e = f_y2;
        else if (rg.c2)         val_e = f_2rest;
        else if (rg.rd | rg.re) val_e = f_1m2xz;
        else                    val_e = '0;
      end
      ptbe_pkg::NODE_M03: begin
        priority if (rg.c0)     val_e = f_z2;
        else if (rg.c3)         val_e = f_2rest;
        else if (rg.ra | rg.re) val_e = f_1m2xy;
        else                    val_e = '0;
      end
      ptbe_pkg::NODE_M13: begin
        priority if (rg.c1)     val_e = f_z2;
        else if (rg.c3)         val_e = f_x2;
        else if (rg.ra | rg.rb) val_e = f_xz2m1;
        else                    val_e = '0;
      end
      ptbe_pkg::NODE_M23: begin
        priority if (rg.c2 | rg.rd) val_e = f_z2;
        else if (rg.c3 | rg.ra)     val_e = f_y2;
        else if (rg.rb)             val_e = f_1m2x;
        else if (rg.re)             val_e = f_xyz2m1;
        else                        val_e = '0;
      end
      default: val_e = '0;
    endcase
  end

  // first partial derivative, axis tests part of most branches
  always_comb begin
    dv_e = '0;
    unique case (s1_node_q)
      ptbe_pkg::NODE_V0: if (rg.c0) dv_e = n2;
      ptbe_pkg::NODE_V1: if (a0 & rg.c1) dv_e = p2;
      ptbe_pkg::NODE_V2: if (a1 & rg.c2) dv_e = p2;
      ptbe_pkg::NODE_V3: if (a2 & rg.c3) dv_e = p2;
      ptbe_pkg::NODE_M01: begin
        priority if (a0 & (rg.c0 | rg.re)) dv_e = p2;
        else if (rg.c1 | rg.rb)            dv_e = n2;
        else if (a2 & rg.ra)               dv_e = n2;
        else if (a1 & rg.rd)               dv_e = n2;
        else                               dv_e = '0;
      end
      ptbe_pkg::NODE_M12: begin
        priority if (a1 & rg.c1)       dv_e = p2;
        else if (a0 & rg.c2)           dv_e = p2;
        else if (~a2 & (rg.rb | rg.rd)) dv_e = p2;
        else                           dv_e = '0;
      end
      ptbe_pkg::NODE_M02: begin
        priority if (a1 & rg.c0)       dv_e = p2;
        else if (rg.c2)                dv_e = n2;
        else if (~a1 & (rg.rd | rg.re)) dv_e = n2;
        else                           dv_e = '0;
      end
      ptbe_pkg::NODE_M03: begin
        priority if (a2 & rg.c0)       dv_e = p2;
        else if (rg.c3)                dv_e = n2;
        else if (~a2 & (rg.ra | rg.re)) dv_e = n2;
        else                           dv_e = '0;
      end
      ptbe_pkg::NODE_M13: begin
        priority if (a2 & rg.c1)       dv_e = p2;
        else if (a0 & rg.c3)           dv_e = p2;
        else if (~a1 & (rg.ra | rg.rb)) dv_e = p2;
        else                           dv_e = '0;
      end
      ptbe_pkg::NODE_M23: begin
        priority if (a2 & (rg.c2 | rg.rd)) dv_e = p2;
        else if (a1 & (rg.c3 | rg.ra))     dv_e = p2;
        else if (a0 & rg.rb)               dv_e = n2;
        else if (rg.re)                    dv_e = p2;
        else                               dv_e = '0;
      end
      default: dv_e = '0;
    endcase
  end

  assign res_e = (s1_kind_q == ptbe_pkg::KIND_DERIV) ? dv_e : val_e;

  // saturate to the output range
  logic signed [ptbe_pkg::OUT_W-1:0] value_d;

  always_comb begin
    priority if (res_e > ptbe_pkg::OUT_MAX_E) begin
      value_d = ptbe_pkg::OUT_MAX_E[ptbe_pkg::OUT_W-1:0];
    end else if (res_e < ptbe_pkg::OUT_MIN_E) begin
      value_d = ptbe_pkg::OUT_MIN_E[ptbe_pkg::OUT_W-1:0];
    end else begin
      value_d = res_e[ptbe_pkg::OUT_W-1:0];
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      value_q <= value_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign value_o     = value_q;

`ifndef SYNTHESIS
  // a derivative item only ever yields zero or plus or minus two
  a_deriv_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && s1_kind_q == ptbe_pkg::KIND_DERIV) |=>
      (value_o == '0 || value_o == ptbe_pkg::TWO_O || value_o == ptbe_pkg::NEG_TWO_O))
    else $error("derivative result out of its set");

  // a node index above nine gives zero
  a_bad_node: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && s1_node_q > ptbe_pkg::NODE_M23) |=> (value_o == '0))
    else $error("unused node gave a non-zero result");

  // the input side stalls only with both registers full and the output stalled
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_vld_q && out_vld_q && out_stall_i))
    else $error("input stalled without cause");

  // an item that advances from the input register reaches the output in the next cycle
  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_valid_o)
    else $error("advanced item lost");
`endif

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

  // widths taken from the package
  localparam int unsigned CW = ptbe_pkg::COORD_W;
  localparam int unsigned NW = ptbe_pkg::NODE_W;
  localparam int unsigned AW = ptbe_pkg::AXIS_W;
  localparam int unsigned OW = ptbe_pkg::OUT_W;

  // fixed point reference levels for stimulus
  localparam int ONE_FX   = 1 << ptbe_pkg::FRAC_BITS;
  localparam int HALF_FX  = ONE_FX / 2;
  localparam int COORD_MAX_FX = (1 << CW) - 1;

  // axis code that names no direction
  localparam logic [AW-1:0] AXIS_NONE = 2'd3;

  // pipeline depth plus margin for the final wait
  localparam int LATENCY_CYCLES = 4;

  logic                     clk_i;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic                     kind_i = ptbe_pkg::KIND_VALUE;
  logic [NW-1:0]            node_i = ptbe_pkg::NODE_V0;
  logic [AW-1:0]            axis_i = ptbe_pkg::AXIS_X;
  logic [CW-1:0]            coord_x_i = '0;
  logic [CW-1:0]            coord_y_i = '0;
  logic [CW-1:0]            coord_z_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic signed [OW-1:0]     value_o;

  // basis results still owed by the block, oldest first
  logic signed [OW-1:0] pending_values[$];

  int  error_count     = 0;
  int  points_sent     = 0;
  int  results_checked = 0;
  bit  no_idle         = 1'b0;

  p1isop2_tet_basis_eval_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .kind_i      (kind_i),
    .node_i      (node_i),
    .axis_i      (axis_i),
    .coord_x_i   (coord_x_i),
    .coord_y_i   (coord_y_i),
    .coord_z_i   (coord_z_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .value_o     (value_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #5ms;
    $display("p1isop2_tet_basis_eval_top test failed");
    $finish;
  end

  // piecewise-linear shape function or its partial derivative at one point
  function automatic logic signed [OW-1:0] basis_at_point(
    input logic          kind,
    input logic [NW-1:0] node,
    input logic [AW-1:0] axis,
    input logic [CW-1:0] cx,
    input logic [CW-1:0] cy,
    input logic [CW-1:0] cz
  );
    longint x, y, z, one, h, two, r, hi, lo;
    bit c0, c1, c2, c3, ra, rb, rd, re, ax, ay, az;
    x   = cx;
    y   = cy;
    z   = cz;
    one = longint'(1) << ptbe_pkg::FRAC_BITS;
    h   = one / 2;
    two = 2 * one;
    hi  = (longint'(1) << (OW - 1)) - 1;
    lo  = -hi - 1;
    // corner pieces, then the four octahedron pieces
    c0 = (x + y + z) <= h;
    c1 = x >= h;
    c2 = y >= h;
    c3 = z >= h;
    ra = (z <= h) && (x + z >= h) && (x + y <= h);
    rb = (x <= h) && (x + y >= h) && (x + z >= h);
    rd = (y <= h) && (x + z <= h) && (x + y >= h);
    re = (x + y <= h) && (x + z <= h) && (x + y + z >= h);
    ax = axis == ptbe_pkg::AXIS_X;
    ay = axis == ptbe_pkg::AXIS_Y;
    az = axis == ptbe_pkg::AXIS_Z;
    r  = 0;
    if (kind == ptbe_pkg::KIND_VALUE) begin
      case (node)
        ptbe_pkg::NODE_V0: if (c0) r = one - 2 * (x + y + z);
        ptbe_pkg::NODE_V1: if (c1) r = 2 * x - one;
        ptbe_pkg::NODE_V2: if (c2) r = 2 * y - one;
        ptbe_pkg::NODE_V3: if (c3) r = 2 * z - one;
        ptbe_pkg::NODE_M01: begin
          if (c0 || re) r = 2 * x;
          else if (c1 || rb) r = 2 * (one - x - y - z);
          else if (ra) r = one - 2 * z;
          else if (rd) r = one - 2 * y;
        end
        ptbe_pkg::NODE_M12: begin
          if (c1) r = 2 * y;
          else if (c2) r = 2 * x;
          else if (rb || rd) r = 2 * (x + y) - one;
        end
        ptbe_pkg::NODE_M02: begin
          if (c0) r = 2 * y;
          else if (c2) r = 2 * (one - x - y - z);
          else if (rd || re) r = one - 2 * (x + z);
        end
        ptbe_pkg::NODE_M03: begin
          if (c0) r = 2 * z;
          else if (c3) r = 2 * (one - x - y - z);
          else if (ra || re) r = one - 2 * (x + y);
        end
        ptbe_pkg::NODE_M13: begin
          if (c1) r = 2 * z;
          else if (c3) r = 2 * x;
          else if (ra || rb) r = 2 * (x + z) - one;
        end
        ptbe_pkg::NODE_M23: begin
          if (c2 || rd) r = 2 * z;
          else if (c3 || ra) r = 2 * y;
          else if (rb) r = one - 2 * x;
          else if (re) r = 2 * (x + y + z) - one;
        end
        default: r = 0;
      endcase
    end else begin
      // derivative: an axis test is part of most branch matches
      case (node)
        ptbe_pkg::NODE_V0: if (c0) r = -two;
        ptbe_pkg::NODE_V1: if (ax && c1) r = two;
        ptbe_pkg::NODE_V2: if (ay && c2) r = two;
        ptbe_pkg::NODE_V3: if (az && c3) r = two;
        ptbe_pkg::NODE_M01: begin
          if (ax && (c0 || re)) r = two;
          else if (c1 || rb) r = -two;
          else if (az && ra) r = -two;
          else if (ay && rd) r = -two;
        end
        ptbe_pkg::NODE_M12: begin
          if (ay && c1) r = two;
          else if (ax && c2) r = two;
          else if (!az && (rb || rd)) r = two;
        end
        ptbe_pkg::NODE_M02: begin
          if (ay && c0) r = two;
          else if (c2) r = -two;
          else if (!ay && (rd || re)) r = -two;
        end
        ptbe_pkg::NODE_M03: begin
          if (az && c0) r = two;
          else if (c3) r = -two;
          else if (!az && (ra || re)) r = -two;
        end
        ptbe_pkg::NODE_M13: begin
          if (az && c1) r = two;
          else if (ax && c3) r = two;
          else if (!ay && (ra || rb)) r = two;
        end
        ptbe_pkg::NODE_M23: begin
          if (az && (c2 || rd)) r = two;
          else if (ay && (c3 || ra)) r = two;
          else if (ax && rb) r = -two;
          else if (re) r = two;
        end
        default: r = 0;
      endcase
    end
    // saturate to the output width
    if (r > hi) r = hi;
    if (r < lo) r = lo;
    return r[OW-1:0];
  endfunction

  // result side back-pressure
  always @(posedge clk_i) begin
    out_stall_i <= !no_idle && ($urandom_range(0, 99) < 14);
  end

  // compare each accepted result with the oldest owed value
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_values.size() == 0) begin
        $error("value: result with no item outstanding, actual %0d", value_o);
        error_count++;
      end else begin
        logic signed [OW-1:0] want;
        want = pending_values.pop_front();
        results_checked++;
        if (value_o !== want) begin
          $error("value mismatch: expected %0d, actual %0d", want, value_o);
          error_count++;
        end
      end
    end
  end

  // present one item, with random gaps unless no_idle is set, and hold it until accepted
  task automatic send_point(
    input logic          kind,
    input logic [NW-1:0] node,
    input logic [AW-1:0] axis,
    input int            cx,
    input int            cy,
    input int            cz
  );
    if (!no_idle) begin
      while ($urandom_range(0, 99) < 14) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    kind_i     <= kind;
    node_i     <= node;
    axis_i     <= axis;
    coord_x_i  <= CW'(cx);
    coord_y_i  <= CW'(cy);
    coord_z_i  <= CW'(cz);
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_values.push_back(basis_at_point(kind, node, axis, CW'(cx),
                                            CW'(cy), CW'(cz)));
    points_sent++;
  endtask

  // stop sending and wait for every owed result
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_values.size() != 0) @(posedge clk_i);
    repeat (LATENCY_CYCLES) @(posedge clk_i);
  endtask

  // mostly points inside the tetrahedron, some on the quarter grid, some anywhere
  task automatic pick_point(output int cx, output int cy, output int cz);
    int mode;
    mode = $urandom_range(0, 99);
    if (mode < 60) begin
      do begin
        cx = $urandom_range(0, ONE_FX);
        cy = $urandom_range(0, ONE_FX);
        cz = $urandom_range(0, ONE_FX);
      end while (cx + cy + cz > ONE_FX);
    end else if (mode < 85) begin
      // quarter grid with one lsb of jitter, to land on region faces
      cx = $urandom_range(0, 4) * (ONE_FX / 4) + $urandom_range(0, 2) - 1;
      cy = $urandom_range(0, 4) * (ONE_FX / 4) + $urandom_range(0, 2) - 1;
      cz = $urandom_range(0, 4) * (ONE_FX / 4) + $urandom_range(0, 2) - 1;
      if (cx < 0) cx = 0;
      if (cy < 0) cy = 0;
      if (cz < 0) cz = 0;
    end else begin
      cx = $urandom_range(0, COORD_MAX_FX);
      cy = $urandom_range(0, COORD_MAX_FX);
      cz = $urandom_range(0, COORD_MAX_FX);
    end
  endtask

  task automatic send_random_points(input int count);
    int cx, cy, cz;
    logic [NW-1:0] node;
    logic [AW-1:0] axis;
    for (int i = 0; i < count; i++) begin
      pick_point(cx, cy, cz);
      node = ($urandom_range(0, 99) < 90) ? NW'($urandom_range(0, 9))
                                          : NW'($urandom_range(10, 15));
      axis = ($urandom_range(0, 99) < 90) ? AW'($urandom_range(0, 2)) : AXIS_NONE;
      send_point(logic'($urandom_range(0, 1)), node, axis, cx, cy, cz);
    end
  endtask

  // each node's value and derivative at its own nodal point
  task automatic test_node_positions();
    int px[10], py[10], pz[10];
    px = '{0, ONE_FX, 0, 0, HALF_FX, HALF_FX, 0, 0, HALF_FX, 0};
    py = '{0, 0, ONE_FX, 0, 0, HALF_FX, HALF_FX, 0, 0, HALF_FX};
    pz = '{0, 0, 0, ONE_FX, 0, 0, 0, HALF_FX, HALF_FX, HALF_FX};
    for (int n = 0; n < 10; n++) begin
      send_point(ptbe_pkg::KIND_VALUE, NW'(n), ptbe_pkg::AXIS_X, px[n], py[n], pz[n]);
      send_point(ptbe_pkg::KIND_DERIV, NW'(n), AW'(n % 3), px[n], py[n], pz[n]);
    end
  endtask

  // saturation, unknown node, no-direction axis, point outside the element
  task automatic test_special_points();
    send_point(ptbe_pkg::KIND_VALUE, ptbe_pkg::NODE_M01, ptbe_pkg::AXIS_X,
               COORD_MAX_FX, COORD_MAX_FX, COORD_MAX_FX);
    send_point(ptbe_pkg::KIND_VALUE, NW'(15), ptbe_pkg::AXIS_Y,
               ONE_FX / 8, ONE_FX / 8, ONE_FX / 8);
    send_point(ptbe_pkg::KIND_DERIV, ptbe_pkg::NODE_M12, AXIS_NONE,
               HALF_FX / 2, HALF_FX / 2, HALF_FX / 2);
    send_point(ptbe_pkg::KIND_VALUE, ptbe_pkg::NODE_V0, ptbe_pkg::AXIS_Z,
               ONE_FX, ONE_FX, ONE_FX);
  endtask

  task automatic test_random_mix(input int count);
    send_random_points(count);
  endtask

  // neither side idles for a long stretch
  task automatic test_back_to_back(input int count);
    no_idle = 1'b1;
    send_random_points(count);
    no_idle = 1'b0;
  endtask

  // sender holds off until the pipeline has emptied, then resumes
  task automatic test_pause_until_drained();
    send_random_points(20);
    drain_results();
    send_random_points(20);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_node_positions();
    test_special_points();
    test_random_mix(400);
    test_back_to_back(200);
    test_pause_until_drained();
    test_random_mix(310);
    drain_results();

    $display("sent %0d points over all nodes, both kinds and all axis codes,", points_sent);
    $display("incl. region faces, outside points and saturation; %0d results compared",
             results_checked);
    if (error_count == 0) begin
      $display("p1isop2_tet_basis_eval_top test passed");
    end else begin
      $display("p1isop2_tet_basis_eval_top test failed");
    end
    $finish;
  end

endmodule
